@@ rtl/ssm_pkg.sv @@
// ============================================================================
// ssm_pkg
// Shared types, constants and helpers for the streaming substring matcher.
// ============================================================================
`default_nettype none

package ssm_pkg;

    // pattern storage is four 64-bit words of eight bytes each
    localparam int unsigned PATTERN_MAX_DEFAULT = 32;
    localparam int unsigned PATTERN_WORDS       = 4;
    localparam int unsigned PATTERN_WORD_W      = 64;
    localparam int unsigned PATTERN_BITS        = PATTERN_WORDS * PATTERN_WORD_W;
    localparam int unsigned PAT_IDX_W           = 5;
    localparam int unsigned LEN_W               = 6;
    localparam int unsigned BYTE_W              = 8;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_CASE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_RESULT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_0 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_1 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_2 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_3 = 3'd7;

    typedef enum logic [1:0] {
        MODE_CONTAINS = 2'd0,
        MODE_BEGINS   = 2'd1,
        MODE_ENDS     = 2'd2,
        MODE_EQUALS   = 2'd3
    } match_mode_t;

    // register file contents as seen by the datapath
    typedef struct packed {
        match_mode_t              match_mode;
        logic                     exact_case;
        logic                     invert_result;
        logic [LEN_W-1:0]         pattern_length;
        logic [PATTERN_BITS-1:0]  pattern;
    } cfg_t;

    // fold ASCII upper-case letters to lower case unless exact compare
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic exact_case);
        logic [BYTE_W-1:0] r;
        r = b;
        if (!exact_case && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssm_cfg_regs.sv @@
// ============================================================================
// ssm_cfg_regs
// Configuration register file: mode, case folding, inversion and pattern.
// ============================================================================
`default_nettype none

module ssm_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ssm_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ssm_pkg::cfg_t                        cfg
);
    import ssm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MATCH_MODE:     cfg_next.match_mode     = match_mode_t'(cfg_wr_data[1:0]);
                CFG_EXACT_CASE:     cfg_next.exact_case     = cfg_wr_data[0];
                CFG_INVERT_RESULT:  cfg_next.invert_result  = cfg_wr_data[0];
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_wr_data[LEN_W-1:0];
                CFG_PATTERN_WORD_0: cfg_next.pattern[0*PATTERN_WORD_W +: PATTERN_WORD_W] =
                                        cfg_wr_data;
                CFG_PATTERN_WORD_1: cfg_next.pattern[1*PATTERN_WORD_W +: PATTERN_WORD_W] =
                                        cfg_wr_data;
                CFG_PATTERN_WORD_2: cfg_next.pattern[2*PATTERN_WORD_W +: PATTERN_WORD_W] =
                                        cfg_wr_data;
                CFG_PATTERN_WORD_3: cfg_next.pattern[3*PATTERN_WORD_W +: PATTERN_WORD_W] =
                                        cfg_wr_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ssm_cell.sv @@
// ============================================================================
// ssm_cell
// One window cell: holds one recent text byte, passes it on each accepted text byte and
// checks the byte it takes in against its pattern position for the suffix.
// ============================================================================
`default_nettype none

module ssm_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              shift_en,
    input  wire logic [ssm_pkg::BYTE_W-1:0]        byte_in,
    input  wire logic [ssm_pkg::LEN_W-1:0]         plen,
    input  wire logic [ssm_pkg::PATTERN_BITS-1:0]  pattern,
    input  wire logic                              exact_case,
    output logic      [ssm_pkg::BYTE_W-1:0]        byte_out,
    output logic                                   hit
);
    import ssm_pkg::*;

    localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(CELL_INDEX);

    logic [BYTE_W-1:0]    byte_reg;
    logic [LEN_W-1:0]     sel_full;
    logic [PAT_IDX_W-1:0] sel;
    logic [BYTE_W-1:0]    pat_b;
    logic                 in_use;

    // cell k lines up with pattern byte plen-1-k
    assign sel_full = plen - CELL_POS - LEN_W'(1);
    assign sel      = sel_full[PAT_IDX_W-1:0];
    assign pat_b    = pattern[sel*BYTE_W +: BYTE_W];
    assign in_use   = CELL_POS < plen;

    // cells past the pattern end always agree
    assign hit = !in_use ||
                 (fold_byte(byte_in, exact_case) == fold_byte(pat_b, exact_case));

    // window shift
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

@@ rtl/streaming_substring_matcher_core.sv @@
// ============================================================================
// streaming_substring_matcher_core
// Streams a text one byte per request and reports contains / begins with /
// ends with / equals against a configured pattern of up to 32 bytes.
// ============================================================================
//
//  channel   direction  tdata                tlast         tuser
//  s_        in         [7:0] text_byte      is_last       [0] is_empty
//  m_        out        [0] matched          -             -
//  cfg_wr_   in         8 registers, index 0..7, 64-bit write data
//
//  One text byte is taken every cycle unless the input stalls; the verdict for a text appears in the
//  output register the cycle after its last byte (or empty-text request).
//  The byte window is a chain of PATTERN_MAX cells that all compare in the
//  same cycle, so the rate is one byte per cycle.
//  The input stalls only while a verdict waits in the output register and
//  m_tready is low. Reset is synchronous, active low, and clears the
//  configuration, the text state and the output register.
//
`default_nettype none

module streaming_substring_matcher_core #(
    parameter int unsigned PATTERN_MAX = ssm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // text input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  wire logic                            s_tlast,   // is_last
    input  wire logic [0:0]                      s_tuser,   // [0] is_empty
    // verdict output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [7:0]                      m_tdata,   // [0] matched, [7:1] zero
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [ssm_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import ssm_pkg::*;

    localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] SEEN_SAT = {LEN_W{1'b1}};

    cfg_t cfg;

    logic [LEN_W-1:0]  plen;
    logic              accept;
    logic              is_empty;
    logic              byte_take;

    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic              prefix_ok_reg, prefix_ok_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_match_reg, out_match_next;

    logic [LEN_W-1:0]  seen_inc;
    logic [BYTE_W-1:0] head_pat;
    logic              head_mismatch;
    logic              suffix;
    logic              prefix_now;
    logic              found_now;
    logic              verdict;

    logic [BYTE_W-1:0]      win_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit_vec;

    // configuration registers
    ssm_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // effective pattern length
    assign plen = (cfg.pattern_length > PLEN_MAX) ? PLEN_MAX : cfg.pattern_length;

    // handshake: the output register frees up the input side
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_empty  = s_tuser[0];
    assign byte_take = accept && !is_empty;

    // window chain, newest byte enters cell 0
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [BYTE_W-1:0] cell_in;
        if (k == 0) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_body
            assign cell_in = win_byte[k-1];
        end
        ssm_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .aclk       (aclk),
            .shift_en   (byte_take),
            .byte_in    (cell_in),
            .plen       (plen),
            .pattern    (cfg.pattern),
            .exact_case (cfg.exact_case),
            .byte_out   (win_byte[k]),
            .hit        (hit_vec[k])
        );
    end

    // byte count including this byte, saturating
    assign seen_inc = (seen_reg == SEEN_SAT) ? SEEN_SAT : seen_reg + LEN_W'(1);

    // prefix check of this byte against pattern position seen_reg
    assign head_pat      = cfg.pattern[seen_reg[PAT_IDX_W-1:0]*BYTE_W +: BYTE_W];
    assign head_mismatch = (seen_reg < plen) &&
                           (fold_byte(s_tdata, cfg.exact_case) !=
                            fold_byte(head_pat, cfg.exact_case));

    // suffix match with this byte as the newest
    assign suffix     = (seen_inc >= plen) && (&hit_vec);
    assign prefix_now = prefix_ok_reg && !head_mismatch;
    assign found_now  = found_reg || suffix;

    // verdict by mode
    always_comb begin
        case (cfg.match_mode)
            MODE_CONTAINS: verdict = found_now;
            MODE_BEGINS:   verdict = prefix_now && (seen_inc >= plen);
            MODE_ENDS:     verdict = suffix;
            MODE_EQUALS:   verdict = prefix_now && (seen_inc == plen);
            default:       verdict = 1'b0;
        endcase
    end

    // text state and output register
    always_comb begin
        seen_next      = seen_reg;
        prefix_ok_next = prefix_ok_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_match_next = out_match_reg;
        if (accept) begin
            if (is_empty) begin
                seen_next      = '0;
                prefix_ok_next = 1'b1;
                found_next     = 1'b0;
                out_valid_next = 1'b1;
                out_match_next = cfg.invert_result;
            end else if (s_tlast) begin
                seen_next      = '0;
                prefix_ok_next = 1'b1;
                found_next     = 1'b0;
                out_valid_next = 1'b1;
                out_match_next = verdict ^ cfg.invert_result;
            end else begin
                seen_next      = seen_inc;
                prefix_ok_next = prefix_now;
                found_next     = found_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            prefix_ok_reg <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_match_reg <= 1'b0;
        end else begin
            seen_reg      <= seen_next;
            prefix_ok_reg <= prefix_ok_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_match_reg <= out_match_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_match_reg};

endmodule

`default_nettype wire
